// ===== rtl/qvr_pkg.sv =====
`default_nettype none

package qvr_pkg;

   localparam int QUAT_WIDTH      = 16;
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int ROUND_SHIFT     = 28;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] QUAT_X_INDEX = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] QUAT_Y_INDEX = 4'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] QUAT_Z_INDEX = 4'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] QUAT_W_INDEX = 4'd3;

   localparam logic signed [QUAT_WIDTH-1:0] QUAT_W_RESET = 16'sd16384;

   typedef struct packed {
      logic signed [QUAT_WIDTH-1:0] x;
      logic signed [QUAT_WIDTH-1:0] y;
      logic signed [QUAT_WIDTH-1:0] z;
      logic signed [QUAT_WIDTH-1:0] w;
   } quat_type;

endpackage

`default_nettype wire

// ===== rtl/qvr_fwd.sv =====
`default_nettype none

// First Hamilton product t = q * (v, 0): one stage of products, one stage of sums.
module qvr_fwd import qvr_pkg::*; #(
   parameter int VEC_WIDTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire quat_type                      quat,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire logic signed [VEC_WIDTH-1:0]   vec_x,
   input  wire logic signed [VEC_WIDTH-1:0]   vec_y,
   input  wire logic signed [VEC_WIDTH-1:0]   vec_z,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic signed [VEC_WIDTH+17:0]       t_w,
   output logic signed [VEC_WIDTH+17:0]       t_x,
   output logic signed [VEC_WIDTH+17:0]       t_y,
   output logic signed [VEC_WIDTH+17:0]       t_z
);

   localparam int P = VEC_WIDTH + QUAT_WIDTH;
   localparam int T = VEC_WIDTH + 18;

   logic signed [P-1:0] qx, qy, qz, qw, vx, vy, vz;
   logic signed [P-1:0] prod_in [12];
   logic signed [P-1:0] prod_ff [12];
   logic signed [T-1:0] e [12];
   logic signed [T-1:0] tw_in, tx_in, ty_in, tz_in;
   logic signed [T-1:0] tw_ff, tx_ff, ty_ff, tz_ff;
   logic valid1_ff, valid1_in, valid2_ff, valid2_in;
   logic adv1, adv2;

   assign qx = {{(P-QUAT_WIDTH){quat.x[QUAT_WIDTH-1]}}, quat.x};
   assign qy = {{(P-QUAT_WIDTH){quat.y[QUAT_WIDTH-1]}}, quat.y};
   assign qz = {{(P-QUAT_WIDTH){quat.z[QUAT_WIDTH-1]}}, quat.z};
   assign qw = {{(P-QUAT_WIDTH){quat.w[QUAT_WIDTH-1]}}, quat.w};
   assign vx = {{QUAT_WIDTH{vec_x[VEC_WIDTH-1]}}, vec_x};
   assign vy = {{QUAT_WIDTH{vec_y[VEC_WIDTH-1]}}, vec_y};
   assign vz = {{QUAT_WIDTH{vec_z[VEC_WIDTH-1]}}, vec_z};

   always_comb begin
      prod_in[0]  = qx * vx;
      prod_in[1]  = qy * vy;
      prod_in[2]  = qz * vz;
      prod_in[3]  = qw * vx;
      prod_in[4]  = qy * vz;
      prod_in[5]  = qz * vy;
      prod_in[6]  = qw * vy;
      prod_in[7]  = qx * vz;
      prod_in[8]  = qz * vx;
      prod_in[9]  = qw * vz;
      prod_in[10] = qx * vy;
      prod_in[11] = qy * vx;
   end

   always_comb begin
      for (int i = 0; i < 12; i++) begin
         e[i] = {{(T-P){prod_ff[i][P-1]}}, prod_ff[i]};
      end
      tw_in = -e[0] - e[1] - e[2];
      tx_in = e[3] + e[4] - e[5];
      ty_in = e[6] - e[7] + e[8];
      tz_in = e[9] + e[10] - e[11];
   end

   // A stage takes a new item when it is empty or its item moves on.
   assign adv2      = !valid2_ff || out_ready;
   assign adv1      = !valid1_ff || adv2;
   assign in_ready  = adv1;
   assign valid1_in = adv1 ? in_valid : valid1_ff;
   assign valid2_in = adv2 ? valid1_ff : valid2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         valid1_ff <= valid1_in;
         valid2_ff <= valid2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         prod_ff <= prod_in;
      end
      if (adv2) begin
         tw_ff <= tw_in;
         tx_ff <= tx_in;
         ty_ff <= ty_in;
         tz_ff <= tz_in;
      end
   end

   assign out_valid = valid2_ff;
   assign t_w = tw_ff;
   assign t_x = tx_ff;
   assign t_y = ty_ff;
   assign t_z = tz_ff;

endmodule

`default_nettype wire

// ===== rtl/qvr_back.sv =====
`default_nettype none

// Second Hamilton product r = t * conj(q), vector part only, with the rounding
// bias folded into the sums.
module qvr_back import qvr_pkg::*; #(
   parameter int VEC_WIDTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire quat_type                      quat,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire logic signed [VEC_WIDTH+17:0]  t_w,
   input  wire logic signed [VEC_WIDTH+17:0]  t_x,
   input  wire logic signed [VEC_WIDTH+17:0]  t_y,
   input  wire logic signed [VEC_WIDTH+17:0]  t_z,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic signed [VEC_WIDTH+35:0]       sum_x,
   output logic signed [VEC_WIDTH+35:0]       sum_y,
   output logic signed [VEC_WIDTH+35:0]       sum_z
);

   localparam int T = VEC_WIDTH + 18;
   localparam int R = T + QUAT_WIDTH;
   localparam int S = R + 2;
   localparam logic signed [S-1:0] BIAS = $signed(S'(64'd1 << (ROUND_SHIFT - 1)));

   logic signed [R-1:0] qx, qy, qz, qw, tw, tx, ty, tz;
   logic signed [R-1:0] prod_in [12];
   logic signed [R-1:0] prod_ff [12];
   logic signed [S-1:0] e [12];
   logic signed [S-1:0] sx_in, sy_in, sz_in, sx_ff, sy_ff, sz_ff;
   logic valid1_ff, valid1_in, valid2_ff, valid2_in;
   logic adv1, adv2;

   assign qx = {{(R-QUAT_WIDTH){quat.x[QUAT_WIDTH-1]}}, quat.x};
   assign qy = {{(R-QUAT_WIDTH){quat.y[QUAT_WIDTH-1]}}, quat.y};
   assign qz = {{(R-QUAT_WIDTH){quat.z[QUAT_WIDTH-1]}}, quat.z};
   assign qw = {{(R-QUAT_WIDTH){quat.w[QUAT_WIDTH-1]}}, quat.w};
   assign tw = {{QUAT_WIDTH{t_w[T-1]}}, t_w};
   assign tx = {{QUAT_WIDTH{t_x[T-1]}}, t_x};
   assign ty = {{QUAT_WIDTH{t_y[T-1]}}, t_y};
   assign tz = {{QUAT_WIDTH{t_z[T-1]}}, t_z};

   always_comb begin
      prod_in[0]  = qx * tw;
      prod_in[1]  = qw * tx;
      prod_in[2]  = qz * ty;
      prod_in[3]  = qy * tz;
      prod_in[4]  = qy * tw;
      prod_in[5]  = qz * tx;
      prod_in[6]  = qw * ty;
      prod_in[7]  = qx * tz;
      prod_in[8]  = qz * tw;
      prod_in[9]  = qy * tx;
      prod_in[10] = qx * ty;
      prod_in[11] = qw * tz;
   end

   always_comb begin
      for (int i = 0; i < 12; i++) begin
         e[i] = {{(S-R){prod_ff[i][R-1]}}, prod_ff[i]};
      end
      sx_in = BIAS - e[0] + e[1] - e[2] + e[3];
      sy_in = BIAS - e[4] + e[5] + e[6] - e[7];
      sz_in = BIAS - e[8] - e[9] + e[10] + e[11];
   end

   assign adv2      = !valid2_ff || out_ready;
   assign adv1      = !valid1_ff || adv2;
   assign in_ready  = adv1;
   assign valid1_in = adv1 ? in_valid : valid1_ff;
   assign valid2_in = adv2 ? valid1_ff : valid2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         valid1_ff <= valid1_in;
         valid2_ff <= valid2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         prod_ff <= prod_in;
      end
      if (adv2) begin
         sx_ff <= sx_in;
         sy_ff <= sy_in;
         sz_ff <= sz_in;
      end
   end

   assign out_valid = valid2_ff;
   assign sum_x = sx_ff;
   assign sum_y = sy_ff;
   assign sum_z = sz_ff;

endmodule

`default_nettype wire

// ===== rtl/qvr_round.sv =====
`default_nettype none

// Drops the fraction bits of the biased sums and saturates to the output width.
module qvr_round import qvr_pkg::*; #(
   parameter int VEC_WIDTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire logic signed [VEC_WIDTH+35:0]  sum_x,
   input  wire logic signed [VEC_WIDTH+35:0]  sum_y,
   input  wire logic signed [VEC_WIDTH+35:0]  sum_z,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic signed [VEC_WIDTH-1:0]        rot_x,
   output logic signed [VEC_WIDTH-1:0]        rot_y,
   output logic signed [VEC_WIDTH-1:0]        rot_z,
   output logic                               clipped
);

   localparam int S = VEC_WIDTH + 36;
   localparam int H = S - ROUND_SHIFT;

   logic signed [H-1:0]         sh [3];
   logic signed [VEC_WIDTH-1:0] sat [3];
   logic [2:0]                  clip;
   logic signed [VEC_WIDTH-1:0] rx_ff, ry_ff, rz_ff;
   logic                        clip_ff, valid_ff, adv;

   assign sh[0] = sum_x[S-1:ROUND_SHIFT];
   assign sh[1] = sum_y[S-1:ROUND_SHIFT];
   assign sh[2] = sum_z[S-1:ROUND_SHIFT];

   // The value fits when every bit above the output sign bit copies the sign.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (!sh[i][H-1] && (|sh[i][H-2:VEC_WIDTH-1])) begin
            sat[i]  = {1'b0, {(VEC_WIDTH-1){1'b1}}};
            clip[i] = 1'b1;
         end else if (sh[i][H-1] && !(&sh[i][H-2:VEC_WIDTH-1])) begin
            sat[i]  = {1'b1, {(VEC_WIDTH-1){1'b0}}};
            clip[i] = 1'b1;
         end else begin
            sat[i]  = sh[i][VEC_WIDTH-1:0];
            clip[i] = 1'b0;
         end
      end
   end

   assign adv      = !valid_ff || out_ready;
   assign in_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rx_ff   <= sat[0];
         ry_ff   <= sat[1];
         rz_ff   <= sat[2];
         clip_ff <= |clip;
      end
   end

   assign out_valid = valid_ff;
   assign rot_x     = rx_ff;
   assign rot_y     = ry_ff;
   assign rot_z     = rz_ff;
   assign clipped   = clip_ff;

endmodule

`default_nettype wire

// ===== rtl/quaternion_vector_rotate_unit.sv =====
// Rotates a vector by the configured quaternion q, giving the vector part of
// q * (v, 0) * conj(q), rounded to nearest from Q28 and saturated.
// Configuration: csr_index selects quat_x, quat_y, quat_z, quat_w (0 to 3) and
// csr_data carries a Q1.14 value; csr_ready is always high, other indexes are
// ignored. Write the quaternion only while no item is in flight.
// Request channel: req_vec_x/y/z are taken at an edge where req_valid is high
// and req_stall is low. Response channel: rsp_rot_x/y/z and rsp_clipped leave
// at an edge where rsp_valid is high and rsp_stall is low.
// Each accepted item passes through five registered stages: products of q and v,
// sums into t, products of t and q, biased sums, then round and saturate.
// Throughput is one item per cycle while rsp_stall is low; every stage has its own valid bit.
// When the receiver stalls, the result holds and earlier stages keep filling
// empty slots; req_stall rises only once all five stages hold items.
// Reset empties the pipeline and sets the quaternion to identity (w = 1.0).
`default_nettype none

module quaternion_vector_rotate_unit import qvr_pkg::*; #(
   parameter int VEC_WIDTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire logic [QUAT_WIDTH-1:0]         csr_data,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [VEC_WIDTH-1:0]   req_vec_x,
   input  wire logic signed [VEC_WIDTH-1:0]   req_vec_y,
   input  wire logic signed [VEC_WIDTH-1:0]   req_vec_z,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [VEC_WIDTH-1:0]        rsp_rot_x,
   output logic signed [VEC_WIDTH-1:0]        rsp_rot_y,
   output logic signed [VEC_WIDTH-1:0]        rsp_rot_z,
   output logic                               rsp_clipped
);

   quat_type quat_ff;
   logic     fwd_ready, back_ready, round_ready;
   logic     fwd_valid, back_valid;
   logic signed [VEC_WIDTH+17:0] t_w, t_x, t_y, t_z;
   logic signed [VEC_WIDTH+35:0] sum_x, sum_y, sum_z;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         quat_ff.x <= '0;
         quat_ff.y <= '0;
         quat_ff.z <= '0;
         quat_ff.w <= QUAT_W_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            QUAT_X_INDEX: quat_ff.x <= csr_data;
            QUAT_Y_INDEX: quat_ff.y <= csr_data;
            QUAT_Z_INDEX: quat_ff.z <= csr_data;
            QUAT_W_INDEX: quat_ff.w <= csr_data;
            default: ;
         endcase
      end
   end

   qvr_fwd #(.VEC_WIDTH(VEC_WIDTH)) u_fwd (
      .clock     (clock),
      .reset     (reset),
      .quat      (quat_ff),
      .in_valid  (req_valid),
      .in_ready  (fwd_ready),
      .vec_x     (req_vec_x),
      .vec_y     (req_vec_y),
      .vec_z     (req_vec_z),
      .out_valid (fwd_valid),
      .out_ready (back_ready),
      .t_w       (t_w),
      .t_x       (t_x),
      .t_y       (t_y),
      .t_z       (t_z)
   );

   qvr_back #(.VEC_WIDTH(VEC_WIDTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .quat      (quat_ff),
      .in_valid  (fwd_valid),
      .in_ready  (back_ready),
      .t_w       (t_w),
      .t_x       (t_x),
      .t_y       (t_y),
      .t_z       (t_z),
      .out_valid (back_valid),
      .out_ready (round_ready),
      .sum_x     (sum_x),
      .sum_y     (sum_y),
      .sum_z     (sum_z)
   );

   qvr_round #(.VEC_WIDTH(VEC_WIDTH)) u_round (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (back_valid),
      .in_ready  (round_ready),
      .sum_x     (sum_x),
      .sum_y     (sum_y),
      .sum_z     (sum_z),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .rot_x     (rsp_rot_x),
      .rot_y     (rsp_rot_y),
      .rot_z     (rsp_rot_z),
      .clipped   (rsp_clipped)
   );

   assign req_stall = !fwd_ready;

endmodule

`default_nettype wire
